>>> sv/nvss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nvss_pkg
// Shared types and codes of the nearest value slot scheduler.
// ----------------------------------------------------------------------------
package nvss_pkg;

    // fixed field widths
    localparam int CFG_W      = 5;
    localparam int SRC_W      = 4;
    localparam int SLOT_OUT_W = 4;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDERS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCES_IN_USE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_POSTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SERVED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FINISHED  = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic needs_scan;
        logic scan_last;
    } t_stat;

endpackage
`default_nettype wire

>>> sv/nearest_value_slot_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_value_slot_scheduler
// Slot board scheduler serving the request nearest the last served value.
// ----------------------------------------------------------------------------
// Posts, and serves that answer finished or not ready at once, are answered
// without a scan: the result is registered at the edge the request is taken. A
// serve that picks a request goes through accept, one slot memory read per slot,
// a compare flush and commit, as the scan walks the slot value memory in slot
// order through its single read port. A new request is taken while the previous
// result still waits on the output, as long as the output register frees at
// that edge. Configuration writes are always ready; they take effect at once.
module nearest_value_slot_scheduler #(
    parameter int SLOTS      = 16,
    parameter int VALUE_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [nvss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [nvss_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_mode,
    input  wire logic [nvss_pkg::SRC_W-1:0]        i_source_index,
    input  wire logic [VALUE_BITS-1:0]             i_request_value,
    input  wire logic                              i_is_last,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [nvss_pkg::STATUS_W-1:0]          o_status,
    output logic [nvss_pkg::SLOT_OUT_W-1:0]        o_served_slot,
    output logic [VALUE_BITS-1:0]                  o_served_value
);
    import nvss_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    nvss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    nvss_datapath #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_source_index  (i_source_index),
        .i_request_value (i_request_value),
        .i_is_last       (i_is_last),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_status        (o_status),
        .o_served_slot   (o_served_slot),
        .o_served_value  (o_served_value)
    );

endmodule
`default_nettype wire

>>> sv/nvss_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nvss_datapath
// Slot board, scheduler counters, nearest value scan and result register.
// ----------------------------------------------------------------------------
module nvss_datapath #(
    parameter int SLOTS      = 16,
    parameter int VALUE_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [nvss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [nvss_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_mode,
    input  wire logic [nvss_pkg::SRC_W-1:0]        i_source_index,
    input  wire logic [VALUE_BITS-1:0]             i_request_value,
    input  wire logic                              i_is_last,
    input  wire nvss_pkg::t_cmd                    i_cmd,
    output nvss_pkg::t_stat                        o_stat,
    output logic [nvss_pkg::STATUS_W-1:0]          o_status,
    output logic [nvss_pkg::SLOT_OUT_W-1:0]        o_served_slot,
    output logic [VALUE_BITS-1:0]                  o_served_value
);
    import nvss_pkg::*;

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int DW    = VALUE_BITS + 1;
    localparam int LW    = VALUE_BITS + 1;
    localparam logic [6:0]    SLOTS_L  = 7'(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    logic [VALUE_BITS-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0]      r_valid;
    logic [SLOTS-1:0]      r_last;
    logic [CFG_W-1:0]      r_max_orders;
    logic [CFG_W-1:0]      r_sources;
    logic [CFG_W-1:0]      r_live;
    logic [CNT_W-1:0]      r_count;
    logic [LW-1:0]         r_last_served;

    logic [IW-1:0]         r_addr;
    logic [VALUE_BITS-1:0] r_rd_data;
    logic                  r_rd_valid;
    logic [IW-1:0]         r_rd_idx;
    logic                  r_cmp_en;
    logic                  r_found;
    logic [IW-1:0]         r_best_idx;
    logic [VALUE_BITS-1:0] r_best_val;
    logic [DW-1:0]         r_best_d;

    logic [STATUS_W-1:0]   r_status;
    logic [SLOT_OUT_W-1:0] r_slot;
    logic [VALUE_BITS-1:0] r_value;

    logic [IW+SRC_W-1:0]      src_wide;
    logic [IW-1:0]            src_idx;
    logic                     in_range;
    logic                     slot_taken;
    logic [CMP_W-1:0]         count_c;
    logic [CMP_W-1:0]         max_c;
    logic [CMP_W-1:0]         live_c;
    logic [CMP_W-1:0]         need_c;
    logic                     count_zero;
    logic                     post_ok;
    logic                     post_we;
    logic                     needs_scan;
    logic                     load_imm;
    logic [STATUS_W-1:0]      imm_status;
    logic [VALUE_BITS+1:0]    diff;
    logic [VALUE_BITS+1:0]    abs_diff;
    logic [DW-1:0]            seek_d;
    logic                     better;
    logic [IW+SLOT_OUT_W-1:0] best_wide;

    assign src_wide   = {{IW{1'b0}}, i_source_index};
    assign src_idx    = src_wide[IW-1:0];
    assign in_range   = ({1'b0, i_source_index} < r_sources) &&
                        ({3'b000, i_source_index} < SLOTS_L);
    // out of range sources read as taken
    assign slot_taken = !in_range || r_valid[src_idx];

    assign count_c    = CMP_W'(r_count);
    assign max_c      = CMP_W'(r_max_orders);
    assign live_c     = CMP_W'(r_live);
    assign need_c     = (max_c < live_c) ? max_c : live_c;
    assign count_zero = (r_count == '0);
    assign post_ok    = !slot_taken && (count_c < max_c);
    assign post_we    = i_cmd.accept && !i_mode && post_ok;
    assign needs_scan = i_mode && !count_zero && !(count_c < need_c);
    assign load_imm   = i_cmd.accept && !needs_scan;

    assign o_stat.needs_scan = needs_scan;
    assign o_stat.scan_last  = (r_addr == LAST_IDX);

    always_comb begin
        if (!i_mode) begin
            if (slot_taken) begin
                imm_status = ST_BUSY;
            end else if (!(count_c < max_c)) begin
                imm_status = ST_FULL;
            end else begin
                imm_status = ST_POSTED;
            end
        end else if (count_zero && (r_live == '0)) begin
            imm_status = ST_FINISHED;
        end else begin
            imm_status = ST_NOT_READY;
        end
    end

    // distance to last served value, last served is signed (reset minus one)
    assign diff     = {2'b00, r_rd_data} - {r_last_served[LW-1], r_last_served};
    assign abs_diff = diff[VALUE_BITS+1] ? (~diff + 1'b1) : diff;
    assign seek_d   = abs_diff[DW-1:0];
    // strict compare keeps the lowest slot on a tie
    assign better   = r_rd_valid && (!r_found || (seek_d < r_best_d));

    assign best_wide = {{SLOT_OUT_W{1'b0}}, r_best_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_orders  <= CFG_RESET;
            r_sources     <= CFG_RESET;
            r_live        <= CFG_RESET;
            r_count       <= '0;
            r_last_served <= '1;
            r_valid       <= '0;
            r_last        <= '0;
            r_addr        <= '0;
            r_cmp_en      <= 1'b0;
            r_found       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_ORDERS) begin
                    r_max_orders <= i_cfg_data;
                end else if (i_cfg_index == CFG_SOURCES_IN_USE) begin
                    r_sources <= i_cfg_data;
                    r_live    <= i_cfg_data;
                end
            end
            if (post_we) begin
                r_valid[src_idx] <= 1'b1;
                r_last[src_idx]  <= i_is_last;
                r_count          <= r_count + 1'b1;
            end
            if (i_cmd.accept && needs_scan) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_addr <= r_addr + 1'b1;
            end
            r_cmp_en <= i_cmd.scan_step;
            if (r_cmp_en && better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit && r_found) begin
                r_valid[r_best_idx] <= 1'b0;
                r_last[r_best_idx]  <= 1'b0;
                if (r_last[r_best_idx] && (r_live != '0)) begin
                    r_live <= r_live - 1'b1;
                end
                if (!count_zero) begin
                    r_count <= r_count - 1'b1;
                end
                r_last_served <= {1'b0, r_best_val};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (post_we) begin
            r_mem[src_idx] <= i_request_value;
        end
        if (i_cmd.scan_step) begin
            r_rd_data  <= r_mem[r_addr];
            r_rd_valid <= r_valid[r_addr];
            r_rd_idx   <= r_addr;
        end
        if (r_cmp_en && better) begin
            r_best_idx <= r_rd_idx;
            r_best_val <= r_rd_data;
            r_best_d   <= seek_d;
        end
        if (load_imm) begin
            r_status <= imm_status;
            r_slot   <= '0;
            r_value  <= '0;
        end else if (i_cmd.commit) begin
            if (r_found) begin
                r_status <= ST_SERVED;
                r_slot   <= best_wide[SLOT_OUT_W-1:0];
                r_value  <= r_best_val;
            end else begin
                r_status <= ST_NOT_READY;
                r_slot   <= '0;
                r_value  <= '0;
            end
        end
    end

    assign o_status       = r_status;
    assign o_served_slot  = r_slot;
    assign o_served_value = r_value;

endmodule
`default_nettype wire

>>> sv/nvss_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nvss_ctrl
// Request sequencer: acceptance, slot scan steps, commit and result valid.
// ----------------------------------------------------------------------------
module nvss_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire logic            i_stall,
    input  wire nvss_pkg::t_stat i_stat,
    output nvss_pkg::t_cmd       o_cmd
);
    import nvss_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   load;

    // result register empties at this edge or already is
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.accept    = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.commit    = 1'b0;
        o_stall         = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall      = !out_free;
                o_cmd.accept = i_valid && out_free;
                if (o_cmd.accept && i_stat.needs_scan) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // last slot read is compared here
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign load = (o_cmd.accept && !i_stat.needs_scan) || o_cmd.commit;

    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !load)
        else $error("result register overwritten while held");

    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_stat.needs_scan) |=> (r_state == S_SCAN))
        else $error("serve did not start a slot scan");

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_stat.scan_last) |=> (r_state == S_FLUSH))
        else $error("slot scan did not end after the last slot");

    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> (r_state == S_DONE && !o_cmd.scan_step))
        else $error("flush did not lead to commit stage");
`endif

endmodule
`default_nettype wire

>>> test/nvss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvss_checker
// Watches the configuration, request and result channels of the nearest value
// slot scheduler, keeps its own copy of the board and predicts every result,
// then compares each accepted result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module nvss_checker #(
    parameter int SLOTS      = 16,
    parameter int VALUE_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [nvss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nvss_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_req_valid,
    input  logic                              i_req_stall,
    input  logic                              i_mode,
    input  logic [nvss_pkg::SRC_W-1:0]        i_source_index,
    input  logic [VALUE_BITS-1:0]             i_request_value,
    input  logic                              i_is_last,
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic [nvss_pkg::STATUS_W-1:0]     i_status,
    input  logic [nvss_pkg::SLOT_OUT_W-1:0]   i_served_slot,
    input  logic [VALUE_BITS-1:0]             i_served_value,
    output int                                o_fail_count,
    output int                                o_pending
);
    import nvss_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [VALUE_BITS-1:0] value;
    } t_sched_result;

    // board copy and configuration
    logic                  slot_busy  [SLOTS];
    logic [VALUE_BITS-1:0] slot_val   [SLOTS];
    logic                  slot_final [SLOTS];
    logic [CFG_W-1:0]      board_count;
    logic [CFG_W-1:0]      live_count;
    logic [CFG_W-1:0]      capacity;
    logic [CFG_W-1:0]      source_limit;
    int                    last_value;

    t_sched_result results_due[$];
    int            fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic void clear_board();
        for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i]  = 1'b0;
            slot_val[i]   = '0;
            slot_final[i] = 1'b0;
        end
        board_count  = '0;
        capacity     = CFG_RESET;
        source_limit = CFG_RESET;
        live_count   = CFG_RESET;
        last_value   = -1;
    endfunction

    function automatic t_sched_result schedule_request(
        input logic                  mode,
        input logic [SRC_W-1:0]      src,
        input logic [VALUE_BITS-1:0] val,
        input logic                  last
    );
        t_sched_result res;
        logic [CFG_W-1:0] need;
        logic             found;
        int               best;
        int               best_d;
        int               d;
        res = '0;
        found = 1'b0;
        best = 0;
        best_d = 0;
        if (!mode) begin
            if ({1'b0, src} >= source_limit || int'(src) >= SLOTS || slot_busy[src]) begin
                res.status = ST_BUSY;
            end else if (board_count >= capacity) begin
                res.status = ST_FULL;
            end else begin
                slot_busy[src]  = 1'b1;
                slot_val[src]   = val;
                slot_final[src] = last;
                board_count++;
                res.status = ST_POSTED;
            end
        end else begin
            need = (capacity < live_count) ? capacity : live_count;
            if (board_count == 0 && live_count == 0) begin
                res.status = ST_FINISHED;
            end else if (board_count == 0 || board_count < need) begin
                res.status = ST_NOT_READY;
            end else begin
                // nearest value to the last one served, lowest slot on a tie
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_busy[i]) begin
                        d = int'(slot_val[i]) - last_value;
                        if (d < 0) d = -d;
                        if (!found || d < best_d) begin
                            found = 1'b1;
                            best = i;
                            best_d = d;
                        end
                    end
                end
                if (!found) begin
                    res.status = ST_NOT_READY;
                end else begin
                    res.status = ST_SERVED;
                    res.slot   = best[SLOT_OUT_W-1:0];
                    res.value  = slot_val[best];
                    last_value = int'(slot_val[best]);
                    if (slot_final[best] && live_count > 0) live_count--;
                    slot_busy[best]  = 1'b0;
                    slot_final[best] = 1'b0;
                    if (board_count > 0) board_count--;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_sched_result want;
        if (!i_rst_n) begin
            clear_board();
            results_due.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with nothing due, status", i_status, -1);
                end else begin
                    want = results_due.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_served_slot !== want.slot)
                        report_mismatch("served slot", i_served_slot, want.slot);
                    if (i_served_value !== want.value)
                        report_mismatch("served value", i_served_value, want.value);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_MAX_ORDERS) begin
                    capacity = i_cfg_data;
                end else if (i_cfg_index == CFG_SOURCES_IN_USE) begin
                    source_limit = i_cfg_data;
                    live_count   = i_cfg_data;
                end
            end
            if (i_req_valid && !i_req_stall) begin
                results_due.push_back(schedule_request(i_mode, i_source_index,
                                                       i_request_value, i_is_last));
            end
        end
        o_pending = results_due.size();
    end

endmodule

>>> test/tb_nearest_value_slot_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_value_slot_scheduler
// Drives the scheduler with a directed opening and then random phases of posts
// and serves under changing board settings and idling; the checker predicts
// and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_nearest_value_slot_scheduler;
    import nvss_pkg::*;

    localparam int SLOTS         = 16;
    localparam int VALUE_BITS    = 10;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 104;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_mode;
    logic [SRC_W-1:0]      i_source_index;
    logic [VALUE_BITS-1:0] i_request_value;
    logic                  i_is_last;
    logic                  o_valid;
    logic                  i_stall;
    logic [STATUS_W-1:0]   o_status;
    logic [SLOT_OUT_W-1:0] o_served_slot;
    logic [VALUE_BITS-1:0] o_served_value;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // board settings per random phase, extremes included
    int phase_cap [PHASES] = '{1, 16, 3, 2, 31, 5, 4, 0, 6, 16, 1, 8};
    int phase_src [PHASES] = '{16, 1, 5, 3, 4, 16, 8, 6, 2, 16, 2, 20};
    logic [VALUE_BITS-1:0] corner_values [6] = '{10'd0, 10'd1, 10'd511, 10'd512,
                                                 10'd1022, 10'd1023};

    nearest_value_slot_scheduler #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_source_index  (i_source_index),
        .i_request_value (i_request_value),
        .i_is_last       (i_is_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_served_slot   (o_served_slot),
        .o_served_value  (o_served_value)
    );

    nvss_checker #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_mode          (i_mode),
        .i_source_index  (i_source_index),
        .i_request_value (i_request_value),
        .i_is_last       (i_is_last),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_status        (o_status),
        .i_served_slot   (o_served_slot),
        .i_served_value  (o_served_value),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver side backpressure
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    task automatic send_request(input logic mode, input logic [SRC_W-1:0] src,
                                input logic [VALUE_BITS-1:0] val, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_source_index  <= src;
        i_request_value <= val;
        i_is_last       <= last;
        do @(posedge i_clk); while (o_stall);
    endtask

    // hold the request side low until every result has come back
    task automatic drain_board();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_settings(input int cap, input int src);
        drain_board();
        write_reg(CFG_MAX_ORDERS, cap);
        write_reg(CFG_SOURCES_IN_USE, src);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic serve_next();
        send_request(1'b1, 4'($urandom), 10'($urandom), 1'($urandom));
    endtask

    initial begin
        int lim;
        logic mode;
        logic [SRC_W-1:0] src;
        logic [VALUE_BITS-1:0] val;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_mode          = 1'b0;
        i_source_index  = '0;
        i_request_value = '0;
        i_is_last       = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening at reset settings: empty board, then too few requests
        send_idle_pct  = 34;
        recv_stall_pct = 78;
        serve_next();
        send_request(1'b0, 4'd15, 10'd1023, 1'b1);
        send_request(1'b0, 4'd15, 10'd5, 1'b0);
        serve_next();

        // small board, slot 15 left over; out of range source, a post, full and busy
        apply_settings(2, 3);
        send_request(1'b0, 4'd3, 10'd7, 1'b0);
        send_request(1'b0, 4'd0, 10'd0, 1'b1);
        send_request(1'b0, 4'd1, 10'd512, 1'b0);
        send_request(1'b0, 4'd0, 10'd9, 1'b0);
        serve_next();
        serve_next();
        send_request(1'b0, 4'd1, 10'd0, 1'b0);
        serve_next();

        // capacity zero: posts refused, leftover still served, then needed count zero
        apply_settings(0, 2);
        send_request(1'b0, 4'd0, 10'd100, 1'b0);
        serve_next();
        serve_next();

        // no sources left: finished, and every post out of range
        apply_settings(31, 0);
        serve_next();
        send_request(1'b0, 4'd0, 10'd3, 1'b1);

        // tie between two slots at equal distance
        apply_settings(4, 16);
        send_request(1'b0, 4'd4, 10'd1000, 1'b0);
        send_request(1'b0, 4'd2, 10'd1000, 1'b1);
        send_request(1'b0, 4'd9, 10'd0, 1'b0);
        send_request(1'b0, 4'd7, 10'd1023, 1'b0);
        serve_next();
        serve_next();
        send_request(1'b0, 4'd7, 10'd990, 1'b0);
        serve_next();

        for (int p = 0; p < PHASES; p++) begin
            apply_settings(phase_cap[p], phase_src[p]);
            case (p / 4)
                0: begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 78;
                end
                1: begin
                    send_idle_pct  = 78;
                    recv_stall_pct = 34;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            lim = (phase_src[p] < 1) ? SLOTS : ((phase_src[p] > SLOTS) ? SLOTS : phase_src[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((p == 0 && n == 50) || $urandom_range(0, 199) == 0) drain_board();
                mode = ($urandom_range(0, 99) < 45);
                if ($urandom_range(0, 9) == 0) begin
                    src = 4'($urandom);
                end else begin
                    src = 4'($urandom_range(0, lim - 1));
                end
                if ($urandom_range(0, 3) == 0) begin
                    val = corner_values[$urandom_range(0, 5)];
                end else begin
                    val = 10'($urandom);
                end
                send_request(mode, src, val, ($urandom_range(0, 5) == 0));
            end
        end

        drain_board();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
